// ===== sv/kpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpsd_pkg
// Shared types, constants and the key map of the keypad scanner.
// ----------------------------------------------------------------------------
package kpsd_pkg;

  localparam int HISTORY_BITS = 8;
  localparam int NUM_ROWS     = 4;
  localparam int NUM_COLS     = 4;
  localparam int NUM_SLOTS    = 2;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef logic [HISTORY_BITS-1:0] hist_t;

  // Keys found pressed on one tick, in row order.
  typedef struct packed {
    logic [NUM_ROWS-1:0]      hit;
    logic [NUM_ROWS-1:0][3:0] idx;
  } push_t;

  // Ring slot: occupied bit above the key index.
  typedef struct packed {
    logic       occ;
    logic [3:0] idx;
  } slot_t;

  typedef struct packed {
    logic [1:0] drive_col;
    logic       key_valid;
    logic [3:0] key_index;
    logic [7:0] key_char;
    logic [1:0] queue_count;
  } result_t;

  localparam logic [7:0] KEY_MAP [16] = '{
    8'h44, 8'h43, 8'h42, 8'h41, 8'h23, 8'h39, 8'h36, 8'h33,
    8'h30, 8'h38, 8'h35, 8'h32, 8'h2a, 8'h37, 8'h34, 8'h31
  };

  function automatic logic [7:0] key_to_char(input logic [3:0] k);
    return KEY_MAP[k];
  endfunction

endpackage

// ===== sv/keypad_scan_debounce_queue_core.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debounce_queue_core
// 4x4 keypad scanner with per-key debounce and a two-slot key ring.
// ----------------------------------------------------------------------------
// Each accepted beat is a scan tick (rows sampled on the driven column) or a
// pop, and yields exactly one result beat. All state updates and the result
// are computed in the cycle of acceptance and land in a two-entry result
// buffer, so one beat per cycle is taken as long as out_stall is low; the
// input stalls only when both buffer entries hold untaken results; out_valid
// is high in the cycle after acceptance. No clearing pass after reset.
module keypad_scan_debounce_queue_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [3:0] in_rows,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_drive_col,
  output logic       out_key_valid,
  output logic [3:0] out_key_index,
  output logic [7:0] out_key_char,
  output logic [1:0] out_queue_count
);

  logic              acc, tick, pop, full, rd_en;
  kpsd_pkg::push_t   push;
  logic [1:0]        col_nxt, count_nxt, oq_cnt;
  logic              key_valid;
  logic [3:0]        key_index;
  kpsd_pkg::result_t res, res_out;

  assign acc      = in_valid && !in_stall;
  assign tick     = acc && (in_action == kpsd_pkg::ACT_TICK);
  assign pop      = acc && (in_action == kpsd_pkg::ACT_POP);
  assign in_stall = full;
  assign rd_en    = out_valid && !out_stall;

  kpsd_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (tick),
    .rows    (in_rows),
    .push    (push),
    .col_nxt (col_nxt)
  );

  kpsd_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (acc),
    .push      (push),
    .pop       (pop),
    .key_valid (key_valid),
    .key_index (key_index),
    .count_nxt (count_nxt)
  );

  always_comb begin
    res.drive_col   = col_nxt;
    res.key_valid   = key_valid;
    res.key_index   = key_index;
    res.key_char    = key_valid ? kpsd_pkg::key_to_char(key_index) : 8'h00;
    res.queue_count = count_nxt;
  end

  kpsd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (acc),
    .wr_data  (res),
    .full     (full),
    .rd_valid (out_valid),
    .rd_en    (rd_en),
    .rd_data  (res_out),
    .cnt      (oq_cnt)
  );

  assign out_drive_col   = res_out.drive_col;
  assign out_key_valid   = res_out.key_valid;
  assign out_key_index   = res_out.key_index;
  assign out_key_char    = res_out.key_char;
  assign out_queue_count = res_out.queue_count;

  a_no_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_key_valid |-> out_key_index == 4'd0 && out_key_char == 8'h00)
    else $error("result without key carries nonzero key fields");

  a_char_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_valid |-> out_key_char == kpsd_pkg::key_to_char(out_key_index))
    else $error("key char does not match key map");

  a_ring_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_queue_count != 2'd3)
    else $error("ring count out of range");

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt != 2'd3)
    else $error("result buffer overflow");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

// ===== sv/kpsd_scan.sv =====
// ----------------------------------------------------------------------------
// kpsd_scan
// Column counter and per-key debounce histories; flags keys whose history
// shows a clean rising edge after a run of lows.
// ----------------------------------------------------------------------------
module kpsd_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  input  logic [3:0]           rows,
  output kpsd_pkg::push_t      push,
  output logic [1:0]           col_nxt
);

  // One history lane per row, addressed by column.
  kpsd_pkg::hist_t hist_r [kpsd_pkg::NUM_ROWS][kpsd_pkg::NUM_COLS];
  kpsd_pkg::hist_t hist_new [kpsd_pkg::NUM_ROWS];
  logic [1:0]      col_r;

  always_comb begin
    for (int r = 0; r < kpsd_pkg::NUM_ROWS; r++) begin
      hist_new[r] = {hist_r[r][col_r][kpsd_pkg::HISTORY_BITS-2:0], rows[r]};
      push.hit[r] = tick && (hist_new[r] == kpsd_pkg::hist_t'(1));
      push.idx[r] = {col_r, 2'(r)};
    end
    col_nxt = tick ? col_r + 2'd1 : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int r = 0; r < kpsd_pkg::NUM_ROWS; r++) begin
        for (int c = 0; c < kpsd_pkg::NUM_COLS; c++) begin
          hist_r[r][c] <= '0;
        end
      end
    end else if (tick) begin
      col_r <= col_nxt;
      for (int r = 0; r < kpsd_pkg::NUM_ROWS; r++) begin
        hist_r[r][col_r] <= hist_new[r];
      end
    end
  end

endmodule

// ===== sv/kpsd_ring.sv =====
// ----------------------------------------------------------------------------
// kpsd_ring
// Two-slot key ring. Pushes overwrite without a full check; a pop takes
// the slot at the read pointer only if it is occupied.
// ----------------------------------------------------------------------------
module kpsd_ring (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  kpsd_pkg::push_t      push,
  input  logic                 pop,
  output logic                 key_valid,
  output logic [3:0]           key_index,
  output logic [1:0]           count_nxt
);

  kpsd_pkg::slot_t slot_r   [kpsd_pkg::NUM_SLOTS];
  kpsd_pkg::slot_t slot_nxt [kpsd_pkg::NUM_SLOTS];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;

  always_comb begin
    slot_nxt  = slot_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    key_valid = 1'b0;
    key_index = '0;
    // Apply pushes in row order.
    for (int r = 0; r < kpsd_pkg::NUM_ROWS; r++) begin
      if (push.hit[r]) begin
        slot_nxt[wp_nxt] = '{occ: 1'b1, idx: push.idx[r]};
        wp_nxt           = ~wp_nxt;
      end
    end
    if (pop && slot_r[rp_r].occ) begin
      key_valid        = 1'b1;
      key_index        = slot_r[rp_r].idx;
      slot_nxt[rp_r]   = '0;
      rp_nxt           = ~rp_r;
    end
    count_nxt = 2'(slot_nxt[0].occ) + 2'(slot_nxt[1].occ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r[0] <= '0;
      slot_r[1] <= '0;
      wp_r      <= 1'b0;
      rp_r      <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
    end
  end

endmodule

// ===== sv/kpsd_outq.sv =====
// ----------------------------------------------------------------------------
// kpsd_outq
// Two-entry result buffer; lets a new beat in while a finished one waits.
// ----------------------------------------------------------------------------
module kpsd_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  kpsd_pkg::result_t    wr_data,
  output logic                 full,
  output logic                 rd_valid,
  input  logic                 rd_en,
  output kpsd_pkg::result_t    rd_data,
  output logic [1:0]           cnt
);

  kpsd_pkg::result_t buf_r [2];
  logic              wptr_r, rptr_r;
  logic [1:0]        cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = buf_r[rptr_r];
  assign cnt      = cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) wptr_r <= ~wptr_r;
      if (rd_en) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== tb/keypad_report_checker.sv =====
// ----------------------------------------------------------------------------
// keypad_report_checker
// Watches both channels of the keypad scanner, predicts every result beat
// from its own copy of the key histories, column and key ring, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module keypad_report_checker
  import kpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_action,
  input  logic [3:0] in_rows,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_drive_col,
  input  logic       out_key_valid,
  input  logic [3:0] out_key_index,
  input  logic [7:0] out_key_char,
  input  logic [1:0] out_queue_count,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Key legend, index 0 in the top byte.
  localparam logic [8*16-1:0] KEY_LEGEND = "DCBA#9630852*741";

  hist_t      hist [16];
  logic [1:0] column;
  slot_t      slots [NUM_SLOTS];
  logic       wr_ptr;
  logic       rd_ptr;
  result_t    expected_reports [$];

  function automatic result_t scan_step(input logic act, input logic [3:0] rows);
    result_t    r;
    logic [3:0] k;
    hist_t      h;
    r = '0;
    if (act == ACT_TICK) begin
      for (int row = 0; row < NUM_ROWS; row++) begin
        k = {column, 2'(row)};
        h = {hist[k][HISTORY_BITS-2:0], rows[row]};
        hist[k] = h;
        // seven quiet samples then a high: register the press, overwrite if full
        if (h == hist_t'(1)) begin
          slots[wr_ptr] = '{occ: 1'b1, idx: k};
          wr_ptr = ~wr_ptr;
        end
      end
      column = column + 2'd1;
    end else if (slots[rd_ptr].occ) begin
      r.key_valid = 1'b1;
      r.key_index = slots[rd_ptr].idx;
      r.key_char  = KEY_LEGEND[8*(15-r.key_index) +: 8];
      slots[rd_ptr] = '0;
      rd_ptr = ~rd_ptr;
    end
    r.drive_col   = column;
    r.queue_count = {1'b0, slots[0].occ} + {1'b0, slots[1].occ};
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
      errors = errors + 1;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) hist[i] = '0;
      slots[0] = '0;
      slots[1] = '0;
      column = '0;
      wr_ptr = 1'b0;
      rd_ptr = 1'b0;
      expected_reports.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors = errors + 1;
        end else begin
          want = expected_reports.pop_front();
          check_field("drive_col", 8'(want.drive_col), 8'(out_drive_col));
          check_field("key_valid", 8'(want.key_valid), 8'(out_key_valid));
          check_field("key_index", 8'(want.key_index), 8'(out_key_index));
          check_field("key_char", want.key_char, out_key_char);
          check_field("queue_count", 8'(want.queue_count), 8'(out_queue_count));
        end
      end
      if (in_valid && !in_stall)
        expected_reports.push_back(scan_step(in_action, in_rows));
      pending <= expected_reports.size();
    end
  end

endmodule

// ===== tb/tb_keypad_scan_debounce_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_keypad_scan_debounce_queue_core
// Drives scan ticks and pops into the keypad scanner and gives the verdict.
// ----------------------------------------------------------------------------
// A short directed run hits ring overwrite, pops of empty slots and ignored
// rows on pop; random beats follow, mostly sparse row samples so that keys
// debounce often. Both sides stall at random, the receiver holds off once
// for a long stretch and the sender once drains the block completely.
// ----------------------------------------------------------------------------
module tb_keypad_scan_debounce_queue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kpsd_pkg::*;

  localparam int RANDOM_BEATS = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_action;
  logic [3:0] in_rows;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_drive_col;
  logic       out_key_valid;
  logic [3:0] out_key_index;
  logic [7:0] out_key_char;
  logic [1:0] out_queue_count;
  int         errors;
  int         pending;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypad_scan_debounce_queue_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_rows(in_rows),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_drive_col(out_drive_col), .out_key_valid(out_key_valid),
    .out_key_index(out_key_index), .out_key_char(out_key_char),
    .out_queue_count(out_queue_count)
  );

  keypad_report_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_rows(in_rows),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_drive_col(out_drive_col), .out_key_valid(out_key_valid),
    .out_key_index(out_key_index), .out_key_char(out_key_char),
    .out_queue_count(out_queue_count),
    .errors(errors), .pending(pending)
  );

  // Offer one beat, hold it until taken.
  task automatic send_beat(input logic act, input logic [3:0] rows);
    if (!quiet) begin
      while ($urandom_range(99) < 7) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_rows   <= rows;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] rows;
    logic       act;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_TICK;
    in_rows   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all four keys of column 0 at once: ring overwritten twice
    send_beat(ACT_TICK, 4'hF);
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_POP, 4'hF);   // empty, rows ignored
    // three keys of column 1 leave the write pointer on the other slot
    send_beat(ACT_TICK, 4'h7);
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_POP, 4'hA);
    send_beat(ACT_POP, 4'h5);
    // one key into slot 1 while the read pointer sits on empty slot 0
    send_beat(ACT_TICK, 4'h1);
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_TICK, 4'h8);
    send_beat(ACT_TICK, 4'h0);
    send_beat(ACT_TICK, 4'hF);  // held keys do not repeat
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_POP, 4'h0);
    send_beat(ACT_POP, 4'h0);
    drain_all();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300) hold_req = 1'b1;
      quiet = (n >= 500 && n < 700);
      if (n == 900) drain_all();
      act = ($urandom_range(99) < 30) ? ACT_POP : ACT_TICK;
      if (act == ACT_POP || $urandom_range(3) == 0) begin
        rows = 4'($urandom);
      end else begin
        // sparse samples: mostly quiet keys with an occasional press
        for (int b = 0; b < NUM_ROWS; b++) rows[b] = ($urandom_range(7) == 0);
      end
      send_beat(act, rows);
    end
    drain_all();
    repeat (4) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/kpsd_pkg.sv
sv/kpsd_scan.sv
sv/kpsd_ring.sv
sv/kpsd_outq.sv
sv/keypad_scan_debounce_queue_core.sv
tb/keypad_report_checker.sv
tb/tb_keypad_scan_debounce_queue_core.sv
